[hdl/lpdp_pkg.sv]
package lpdp_pkg;

  localparam int IMG_W_DEF = 1280;
  localparam int IMG_H_DEF = 720;

  localparam int XYZ_W  = 19;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 10;
  localparam int DEP_W  = 17;
  localparam int FOC_W  = 16;
  localparam int CFGI_W = 3;
  localparam int ST_W   = 3;
  localparam int CAM_W  = 40;
  localparam int MUL_W  = CAM_W + FOC_W + 1;
  localparam int NUM_W  = 64;
  localparam int QB     = 13;

  localparam logic signed [CAM_W-1:0] K_COS = CAM_W'(64332);
  localparam logic signed [CAM_W-1:0] K_SIN = CAM_W'(12505);
  localparam logic signed [CAM_W-1:0] K_TR0 = CAM_W'(36324287);
  localparam logic signed [CAM_W-1:0] K_TR1 = CAM_W'(93952410);
  localparam logic signed [CAM_W-1:0] K_TR2 = -CAM_W'(24151957);
  localparam logic signed [CAM_W-1:0] K_HALF = CAM_W'(32768);

  localparam logic [ST_W-1:0] ST_STORED  = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [ST_W-1:0] ST_OFF     = 3'd3;
  localparam logic [ST_W-1:0] ST_FARTHER = 3'd4;
  localparam logic [ST_W-1:0] ST_READ    = 3'd5;

  localparam logic [CFGI_W-1:0] REG_FOCAL_X = 3'd0;
  localparam logic [CFGI_W-1:0] REG_FOCAL_Y = 3'd1;
  localparam logic [CFGI_W-1:0] REG_CTR_COL = 3'd2;
  localparam logic [CFGI_W-1:0] REG_CTR_ROW = 3'd3;
  localparam logic [CFGI_W-1:0] REG_MIN_DEP = 3'd4;
  localparam logic [CFGI_W-1:0] REG_MAX_DEP = 3'd5;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          neg;
    logic          ovf;
  } div_res_t;

endpackage

[hdl/lpdp_dmem.sv]
module lpdp_dmem #(
  parameter int DEPTH  = 921600,
  parameter int ADDR_W = 20,
  parameter int DATA_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lpdp_rdiv.sv]
module lpdp_rdiv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [lpdp_pkg::NUM_W-1:0] num,
  input  logic [lpdp_pkg::NUM_W-1:0]        den2,
  output logic                             busy,
  output lpdp_pkg::div_res_t               res
);
  import lpdp_pkg::*;

  localparam int CNT_W = $clog2(QB + 1);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dvs_r, dvs_nxt;
  logic [QB-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             ovf_r, ovf_nxt;
  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] a_val;

  // rounded quotient = floor((2|num| + den) / (2 den))
  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign a_val = (mag << 1) + (den2 >> 1);

  always_comb begin
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    ovf_nxt = ovf_r;
    if (start) begin
      rem_nxt = a_val;
      dvs_nxt = den2 << (QB - 1);
      q_nxt   = '0;
      cnt_nxt = CNT_W'(QB);
      neg_nxt = num[NUM_W-1];
      ovf_nxt = a_val >= (den2 << QB);
    end else if (cnt_r != '0) begin
      if (rem_r >= dvs_r) begin
        rem_nxt = rem_r - dvs_r;
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy    = cnt_r != '0;
  assign res.q   = q_r;
  assign res.neg = neg_r;
  assign res.ovf = ovf_r;

endmodule

[hdl/lidar_point_depth_projection_unit.sv]
// channel | port group | handshake        | payload
// input   | in_         | tvalid/tready    | tuser func, tdata point and read fields
// result  | out_        | tvalid/tready    | tuser status, tdata depth/col/row
// config  | cfg_        | we, no wait      | cfg_index, cfg_wdata
// One request at a time. Project: XF, MUL, SUM, DIVLD, DIV, ADDR, RD, RMW, OUT, with DIV
// waiting on the 13-step rounding divider; rejects finish earlier. Read: XF, RD, RMW, OUT,
// or XF to OUT when out of range. After reset a clearing pass writes
// IMAGE_WIDTH*IMAGE_HEIGHT entries (921600 at defaults) with in_tready low; config writes
// are taken during it. A new request is taken while the result register waits on out_tready.
module lidar_point_depth_projection_unit #(
  parameter int IMAGE_WIDTH  = lpdp_pkg::IMG_W_DEF,
  parameter int IMAGE_HEIGHT = lpdp_pkg::IMG_H_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // point_valid, point_x, point_y, point_z, read_col, read_row,
                                 // clear_after_read
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // depth, out_col, out_row, zero fill
  output logic [2:0]  out_tuser, // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import lpdp_pkg::*;

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_XF    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_DIVLD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ADDR  = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_RMW   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  logic [FOC_W-1:0] fx_r, fy_r, cc_r, cr_r;
  logic [DEP_W-1:0] dmin_r, dmax_r;

  logic                    func_r, pv_r, clr_rd_r;
  logic signed [XYZ_W-1:0] px_r, py_r, pz_r;
  logic [COL_W-1:0]        rcol_r;
  logic [ROW_W-1:0]        rrow_r;

  logic signed [CAM_W-1:0] x16_r, y16_r, z16_r;
  logic signed [MUL_W-1:0] pc1_r, pc2_r, pr1_r, pr2_r;
  logic signed [NUM_W-1:0] numc_r, numr_r;
  logic [NUM_W-1:0]        den2_r;
  logic [DEP_W-1:0]        d_r;
  logic [ADDR_W-1:0]       addr_r;

  logic [ST_W-1:0]  rst_r;
  logic [DEP_W-1:0] rdep_r;
  logic [COL_W-1:0] rc_r;
  logic [ROW_W-1:0] rr_r;

  logic             ov_r;
  logic [ST_W-1:0]  ost_r;
  logic [DEP_W-1:0] odep_r;
  logic [COL_W-1:0] oc_r;
  logic [ROW_W-1:0] or_r;

  logic             div_start, div_busy_c, div_busy_r;
  div_res_t         dres_c, dres_r;

  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DEP_W-1:0] mem_wdata, mem_rdata;

  logic             in_acc, out_load;
  logic signed [CAM_W-1:0] dz;
  logic             off_c;

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!ov_r || out_tready);
  assign div_start = state_r == S_DIVLD;
  assign mem_re    = state_r == S_RD;
  assign dz        = (z16_r + K_HALF) >>> 16;

  assign off_c = dres_c.ovf || (dres_c.neg && dres_c.q != '0) || (32'(dres_c.q) >= IMAGE_WIDTH)
              || dres_r.ovf || (dres_r.neg && dres_r.q != '0) || (32'(dres_r.q) >= IMAGE_HEIGHT);

  lpdp_rdiv u_div_col (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numc_r), .den2(den2_r),
    .busy(div_busy_c), .res(dres_c)
  );

  lpdp_rdiv u_div_row (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numr_r), .den2(den2_r),
    .busy(div_busy_r), .res(dres_r)
  );

  lpdp_dmem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(DEP_W)) u_dmem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(addr_r), .rdata(mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
    end else if (state_r == S_RMW) begin
      if (func_r) begin
        mem_we = clr_rd_r;
      end else if (mem_rdata == '0 || d_r < mem_rdata) begin
        mem_we    = 1'b1;
        mem_wdata = d_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE:  if (in_acc) state_nxt = S_XF;
      S_XF: begin
        if (func_r) begin
          if (32'(rcol_r) >= IMAGE_WIDTH || 32'(rrow_r) >= IMAGE_HEIGHT) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RD;
          end
        end else if (!pv_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (dz <= 0 || 24'(dz) < 24'(dmin_r) || 24'(dz) > 24'(dmax_r)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM:   state_nxt = S_DIVLD;
      S_DIVLD: state_nxt = S_DIV;
      S_DIV:   if (!div_busy_c && !div_busy_r) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = off_c ? S_OUT : S_RD;
      S_RD:    state_nxt = S_RMW;
      S_RMW:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      fx_r    <= 16'd10240;
      fy_r    <= 16'd10240;
      cc_r    <= 16'd10240;
      cr_r    <= 16'd5760;
      dmin_r  <= 17'd512;
      dmax_r  <= 17'd81920;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FOCAL_X: fx_r   <= cfg_wdata[FOC_W-1:0];
          REG_FOCAL_Y: fy_r   <= cfg_wdata[FOC_W-1:0];
          REG_CTR_COL: cc_r   <= cfg_wdata[FOC_W-1:0];
          REG_CTR_ROW: cr_r   <= cfg_wdata[FOC_W-1:0];
          REG_MIN_DEP: dmin_r <= cfg_wdata;
          REG_MAX_DEP: dmax_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_tuser;
      pv_r     <= in_tdata[0];
      px_r     <= in_tdata[19:1];
      py_r     <= in_tdata[38:20];
      pz_r     <= in_tdata[57:39];
      rcol_r   <= in_tdata[68:58];
      rrow_r   <= in_tdata[78:69];
      clr_rd_r <= in_tdata[79];
    end
    unique case (state_r)
      S_XF: begin
        z16_r <= K_COS * CAM_W'(pz_r) - K_SIN * CAM_W'(py_r) + K_TR0;
        x16_r <= K_TR1 - (CAM_W'(px_r) <<< 16);
        y16_r <= K_COS * CAM_W'(py_r) + K_SIN * CAM_W'(pz_r) - K_TR2;
        addr_r <= ADDR_W'(rrow_r) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(rcol_r);
        rc_r   <= func_r ? rcol_r : '0;
        rr_r   <= func_r ? rrow_r : '0;
        rdep_r <= '0;
        rst_r  <= func_r ? ST_READ : ST_INVALID;
      end
      S_MUL: begin
        pc1_r <= $signed({1'b0, fx_r}) * x16_r;
        pc2_r <= $signed({1'b0, cc_r}) * z16_r;
        pr1_r <= $signed({1'b0, fy_r}) * y16_r;
        pr2_r <= $signed({1'b0, cr_r}) * z16_r;
        d_r   <= dz[DEP_W-1:0];
        rst_r <= ST_RANGE;
      end
      S_SUM: begin
        numc_r <= NUM_W'(pc1_r) + NUM_W'(pc2_r);
        numr_r <= NUM_W'(pr1_r) + NUM_W'(pr2_r);
        den2_r <= NUM_W'({z16_r, 5'b0});
      end
      S_ADDR: begin
        rst_r  <= ST_OFF;
        rc_r   <= off_c ? '0 : dres_c.q[COL_W-1:0];
        rr_r   <= off_c ? '0 : dres_r.q[ROW_W-1:0];
        addr_r <= ADDR_W'(dres_r.q) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(dres_c.q);
      end
      S_RMW: begin
        if (func_r) begin
          rst_r  <= ST_READ;
          rdep_r <= mem_rdata;
        end else if (mem_rdata == '0 || d_r < mem_rdata) begin
          rst_r  <= ST_STORED;
          rdep_r <= d_r;
        end else begin
          rst_r  <= ST_FARTHER;
          rdep_r <= mem_rdata;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      ost_r  <= rst_r;
      odep_r <= rdep_r;
      oc_r   <= rc_r;
      or_r   <= rr_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {2'b00, or_r, oc_r, odep_r};

  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready) else $error("request taken during clear");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || state_r == S_RMW)) else $error("stray store write");
  a_acc_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_XF) else $error("accept did not start work");
  a_off_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR && off_c) |=> state_r == S_OUT) else $error("off image reached store");
  a_stored_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_STORED) |-> out_tdata[16:0] != '0)
    else $error("stored zero depth");

endmodule
